>>> src/detection_box_decoder_core_defines.svh
// assertion macros shared by the checker files of the box decoder
// expects aclk and aresetn in the scope where a macro is used
`ifndef DETECTION_BOX_DECODER_CORE_DEFINES_SVH
`define DETECTION_BOX_DECODER_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define DBD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define DBD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/dbd_pkg.sv
// shared types and constants of the detection box decoder
// no dependencies
`default_nettype none

package dbd_pkg;

    localparam int MAX_COLUMNS = 512;
    localparam int COL_W       = $clog2(MAX_COLUMNS);
    localparam int COLS_W      = $clog2(MAX_COLUMNS + 1);
    localparam int MIN_COLUMNS = 6;
    localparam int FIRST_CLASS = 5;
    localparam int CLASS_W     = 9;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int ADDR_W = 8;
    localparam int DATA_W = 32;

    localparam logic [ADDR_W-1:0] REG_NUM_COLUMNS     = 8'd0;
    localparam logic [ADDR_W-1:0] REG_SCORE_THRESHOLD = 8'd1;
    localparam logic [ADDR_W-1:0] REG_X_SCALE         = 8'd2;
    localparam logic [ADDR_W-1:0] REG_Y_SCALE         = 8'd3;

    localparam logic signed [31:0] ONE_Q16 = 32'sd65536;

    typedef struct packed {
        logic [COLS_W-1:0] num_columns;
        logic [16:0]       score_threshold;
        logic [23:0]       x_scale;
        logic [23:0]       y_scale;
    } cfg_t;

    typedef struct packed {
        logic signed [31:0] centre_x;
        logic signed [31:0] centre_y;
        logic signed [31:0] box_width;
        logic signed [31:0] box_height;
        logic signed [31:0] objectness;
        logic signed [31:0] class_score;
        logic [CLASS_W-1:0] class_id;
    } task_t;

endpackage

`default_nettype wire

>>> src/dbd_front.sv
// front end: column tracking, row context capture and row acceptance
// depends on dbd_pkg
`default_nettype none

module dbd_front import dbd_pkg::*; (
    input  wire                aclk,
    input  wire                aresetn,
    input  cfg_t               cfg,
    input  wire                in_fire,
    input  wire signed [31:0]  in_value,
    output logic               task_valid,
    output task_t              task_data
);

    logic [COL_W-1:0]   column_index_reg, column_index_next;
    logic signed [31:0] centre_x_reg, centre_y_reg, box_width_reg, box_height_reg;
    logic signed [31:0] objectness_reg;
    logic               row_accepted_reg, row_accepted_next;
    logic [COLS_W-1:0]  cols_eff;
    logic [COLS_W-1:0]  col_plus1;
    logic signed [31:0] thr_s;

    always_comb begin
        if (cfg.num_columns < COLS_W'(MIN_COLUMNS)) begin
            cols_eff = COLS_W'(MIN_COLUMNS);
        end else if (cfg.num_columns > COLS_W'(MAX_COLUMNS)) begin
            cols_eff = COLS_W'(MAX_COLUMNS);
        end else begin
            cols_eff = cfg.num_columns;
        end
    end

    assign col_plus1 = {1'b0, column_index_reg} + COLS_W'(1);
    assign thr_s     = $signed({15'd0, cfg.score_threshold});

    always_comb begin
        column_index_next = column_index_reg;
        row_accepted_next = row_accepted_reg;
        if (in_fire) begin
            column_index_next = (col_plus1 >= cols_eff) ? '0 : col_plus1[COL_W-1:0];
            if (column_index_reg == COL_W'(4)) begin
                row_accepted_next = (in_value > thr_s) && (in_value <= ONE_Q16);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_index_reg <= '0;
            row_accepted_reg <= 1'b0;
            centre_x_reg     <= '0;
            centre_y_reg     <= '0;
            box_width_reg    <= '0;
            box_height_reg   <= '0;
            objectness_reg   <= '0;
        end else begin
            column_index_reg <= column_index_next;
            row_accepted_reg <= row_accepted_next;
            if (in_fire) begin
                unique case (column_index_reg)
                    COL_W'(0): centre_x_reg   <= in_value;
                    COL_W'(1): centre_y_reg   <= in_value;
                    COL_W'(2): box_width_reg  <= in_value;
                    COL_W'(3): box_height_reg <= in_value;
                    COL_W'(4): objectness_reg <= in_value;
                    default: begin
                    end
                endcase
            end
        end
    end

    // class columns of an accepted row go to the back end
    assign task_valid = in_fire && row_accepted_reg
                        && (column_index_reg >= COL_W'(FIRST_CLASS));

    always_comb begin
        task_data.centre_x    = centre_x_reg;
        task_data.centre_y    = centre_y_reg;
        task_data.box_width   = box_width_reg;
        task_data.box_height  = box_height_reg;
        task_data.objectness  = objectness_reg;
        task_data.class_score = in_value;
        task_data.class_id    = CLASS_W'(column_index_reg - COL_W'(FIRST_CLASS));
    end

endmodule

`default_nettype wire

>>> src/dbd_queue.sv
// small flop queue between front and back end
// depends on dbd_pkg
`default_nettype none

module dbd_queue import dbd_pkg::*; (
    input  wire    aclk,
    input  wire    aresetn,
    input  wire    push,
    input  task_t  push_data,
    output logic   not_full,
    output logic   out_valid,
    input  wire    pop,
    output task_t  out_data
);

    task_t             entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] head_reg, head_next;
    logic [QPTR_W-1:0] tail_reg, tail_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign not_full  = (count_reg < QCNT_W'(QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = entry_reg[head_reg];
    assign do_push   = push && not_full;
    assign do_pop    = pop && out_valid;

    always_comb begin
        head_next  = do_pop ? head_reg + QPTR_W'(1) : head_reg;
        tail_next  = do_push ? tail_reg + QPTR_W'(1) : tail_reg;
        count_next = count_reg + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[tail_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

>>> src/dbd_back.sv
// back end: score product, threshold test, corner scaling and output register
// depends on dbd_pkg
`default_nettype none

module dbd_back import dbd_pkg::*; (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  cfg_t                cfg,
    input  wire                 task_valid,
    input  task_t               task_data,
    output logic                task_pop,
    output logic                out_valid,
    input  wire                 out_ready,
    output logic signed [31:0]  out_left,
    output logic signed [31:0]  out_top,
    output logic signed [31:0]  out_right,
    output logic signed [31:0]  out_bottom,
    output logic [CLASS_W-1:0]  out_class_id,
    output logic [16:0]         out_score
);

    logic advance;

    // stage 1: score product and doubled edges
    logic               s1_valid_reg;
    logic signed [63:0] s1_prod_reg;
    logic signed [33:0] s1_el_reg, s1_er_reg, s1_et_reg, s1_eb_reg;
    logic [CLASS_W-1:0] s1_class_reg;

    // stage 2: threshold test and scaled corners
    logic               s2_valid_reg;
    logic               s2_pass_reg;
    logic [16:0]        s2_score_reg;
    logic signed [58:0] s2_cl_reg, s2_cr_reg, s2_ct_reg, s2_cb_reg;
    logic [CLASS_W-1:0] s2_class_reg;

    // stage 3: output register
    logic               s3_valid_reg;

    logic signed [33:0] cx2, cy2, w_ext, h_ext;
    logic signed [63:0] thr_q32;
    logic signed [47:0] prod_shift;
    logic signed [24:0] xs_s, ys_s;

    function automatic logic signed [31:0] sat32(input logic signed [41:0] v);
        logic signed [31:0] r;
        if ((v[41:31] == '0) || (v[41:31] == '1)) begin
            r = v[31:0];
        end else if (v[41]) begin
            r = 32'sh8000_0000;
        end else begin
            r = 32'sh7fff_ffff;
        end
        return r;
    endfunction

    assign advance  = !s3_valid_reg || out_ready;
    assign task_pop = advance;

    assign cx2   = $signed({task_data.centre_x[31], task_data.centre_x, 1'b0});
    assign cy2   = $signed({task_data.centre_y[31], task_data.centre_y, 1'b0});
    assign w_ext = $signed({{2{task_data.box_width[31]}}, task_data.box_width});
    assign h_ext = $signed({{2{task_data.box_height[31]}}, task_data.box_height});

    assign thr_q32    = $signed({31'd0, cfg.score_threshold, 16'd0});
    assign prod_shift = s1_prod_reg[63:16];
    assign xs_s       = $signed({1'b0, cfg.x_scale});
    assign ys_s       = $signed({1'b0, cfg.y_scale});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end else if (advance) begin
            s1_valid_reg <= task_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg && s2_pass_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            s1_prod_reg  <= task_data.class_score * task_data.objectness;
            s1_el_reg    <= cx2 - w_ext;
            s1_er_reg    <= cx2 + w_ext;
            s1_et_reg    <= cy2 - h_ext;
            s1_eb_reg    <= cy2 + h_ext;
            s1_class_reg <= task_data.class_id;

            s2_pass_reg  <= (s1_prod_reg > thr_q32);
            s2_score_reg <= (prod_shift > 48'sd65536) ? 17'd65536 : prod_shift[16:0];
            s2_cl_reg    <= s1_el_reg * xs_s;
            s2_cr_reg    <= s1_er_reg * xs_s;
            s2_ct_reg    <= s1_et_reg * ys_s;
            s2_cb_reg    <= s1_eb_reg * ys_s;
            s2_class_reg <= s1_class_reg;

            out_left     <= sat32(s2_cl_reg[58:17]);
            out_right    <= sat32(s2_cr_reg[58:17]);
            out_top      <= sat32(s2_ct_reg[58:17]);
            out_bottom   <= sat32(s2_cb_reg[58:17]);
            out_class_id <= s2_class_reg;
            out_score    <= s2_score_reg;
        end
    end

    assign out_valid = s3_valid_reg;

endmodule

`default_nettype wire

>>> src/detection_box_decoder_core.sv
// Detection box decoder. Takes one signed Q16.16 detector value per beat, row after row
// (centre x, centre y, width, height, objectness, class scores) and emits one box beat for
// every class of an accepted row whose score times objectness passes the threshold. A value
// is accepted every cycle while the result side keeps up. The front end tracks the column and
// row context, a four-entry queue decouples it from the back end, and the back end is a
// three-stage multiply pipeline whose last stage is the output register, so a stalled result
// side fills the queue before s_ready drops. Configuration writes are taken every cycle and
// belong only in idle periods.
// depends on dbd_pkg, dbd_front, dbd_queue, dbd_back
`default_nettype none

module detection_box_decoder_core import dbd_pkg::*; (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 cfg_valid,
    output logic                cfg_ready,
    input  wire [ADDR_W-1:0]    cfg_addr,
    input  wire [DATA_W-1:0]    cfg_data,
    input  wire                 s_valid,
    output logic                s_ready,
    input  wire signed [31:0]   s_value,
    output logic                m_valid,
    input  wire                 m_ready,
    output logic signed [31:0]  m_box_left,
    output logic signed [31:0]  m_box_top,
    output logic signed [31:0]  m_box_right,
    output logic signed [31:0]  m_box_bottom,
    output logic [CLASS_W-1:0]  m_class_id,
    output logic [16:0]         m_score
);

    cfg_t  cfg_reg;
    logic  in_fire;
    logic  front_valid;
    task_t front_task;
    logic  q_not_full, q_valid, q_pop;
    task_t q_task;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.num_columns     <= COLS_W'(85);
            cfg_reg.score_threshold <= 17'd16384;
            cfg_reg.x_scale         <= 24'd65536;
            cfg_reg.y_scale         <= 24'd65536;
        end else if (cfg_valid) begin
            unique case (cfg_addr)
                REG_NUM_COLUMNS:     cfg_reg.num_columns     <= cfg_data[COLS_W-1:0];
                REG_SCORE_THRESHOLD: cfg_reg.score_threshold <= cfg_data[16:0];
                REG_X_SCALE:         cfg_reg.x_scale         <= cfg_data[23:0];
                REG_Y_SCALE:         cfg_reg.y_scale         <= cfg_data[23:0];
                default: begin
                end
            endcase
        end
    end

    assign s_ready = q_not_full;
    assign in_fire = s_valid && s_ready;

    dbd_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .in_fire    (in_fire),
        .in_value   (s_value),
        .task_valid (front_valid),
        .task_data  (front_task)
    );

    dbd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (front_valid),
        .push_data (front_task),
        .not_full  (q_not_full),
        .out_valid (q_valid),
        .pop       (q_pop),
        .out_data  (q_task)
    );

    dbd_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg_reg),
        .task_valid   (q_valid),
        .task_data    (q_task),
        .task_pop     (q_pop),
        .out_valid    (m_valid),
        .out_ready    (m_ready),
        .out_left     (m_box_left),
        .out_top      (m_box_top),
        .out_right    (m_box_right),
        .out_bottom   (m_box_bottom),
        .out_class_id (m_class_id),
        .out_score    (m_score)
    );

endmodule

`default_nettype wire

>>> src/dbd_checker.sv
// port-level checks of the detection box decoder, bound to the top level
// depends on dbd_pkg and detection_box_decoder_core_defines.svh
`default_nettype none
`include "detection_box_decoder_core_defines.svh"

module dbd_checker import dbd_pkg::*; (
    input wire                 aclk,
    input wire                 aresetn,
    input wire                 m_valid,
    input wire                 m_ready,
    input wire signed [31:0]   m_box_left,
    input wire signed [31:0]   m_box_top,
    input wire signed [31:0]   m_box_right,
    input wire signed [31:0]   m_box_bottom,
    input wire [CLASS_W-1:0]   m_class_id,
    input wire [16:0]          m_score
);

    logic [4*32+CLASS_W+17-1:0] m_payload;
    logic                       class_ok;

    assign m_payload = {m_box_left, m_box_top, m_box_right, m_box_bottom, m_class_id, m_score};
    assign class_ok  = (m_class_id <= CLASS_W'(MAX_COLUMNS - 1 - FIRST_CLASS));

    `DBD_ASSERT_NEXT(a_m_hold, m_valid && !m_ready, m_valid, "result beat dropped while stalled")
    `DBD_ASSERT_NEXT(a_m_stable, m_valid && !m_ready, $stable(m_payload), "stalled beat changed")
    `DBD_ASSERT_NOW(a_score_sat, m_valid, m_score <= 17'd65536, "score above saturation limit")
    `DBD_ASSERT_NOW(a_class_range, m_valid, class_ok, "class index out of range")

endmodule

bind detection_box_decoder_core dbd_checker u_dbd_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_box_left   (m_box_left),
    .m_box_top    (m_box_top),
    .m_box_right  (m_box_right),
    .m_box_bottom (m_box_bottom),
    .m_class_id   (m_class_id),
    .m_score      (m_score)
);

`default_nettype wire

>>> tb/tb_detection_box_decoder_core.sv
`timescale 1ns / 100ps
// self-checking testbench for detection_box_decoder_core: streams detector rows under
// changing register settings and output stalls, checks each box against a local predictor
// depends on dbd_pkg and the detection_box_decoder_core rtl

typedef enum int {
    COL_CENTRE_X = 0,
    COL_CENTRE_Y,
    COL_WIDTH,
    COL_HEIGHT,
    COL_OBJECTNESS
} row_col_t;

typedef enum int {
    SINK_OPEN = 0,
    SINK_BUSY,
    SINK_SPARSE,
    SINK_STRIDE
} sink_mode_t;

typedef struct packed {
    logic signed [31:0] left;
    logic signed [31:0] top;
    logic signed [31:0] right;
    logic signed [31:0] bottom;
    logic [8:0]         class_id;
    logic [16:0]        score;
} box_t;

class box_tracker_t;
    logic [9:0]         cols;
    logic [16:0]        thr;
    logic [23:0]        x_scale;
    logic [23:0]        y_scale;
    int                 col_idx;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] bw;
    logic signed [31:0] bh;
    logic signed [31:0] obj;
    bit                 row_ok;
    box_t               pending_boxes[$];
    int                 errors;
    int                 values_seen;
    int                 boxes_checked;
    int                 reg_writes;

    function new();
        cols          = 10'd85;
        thr           = 17'd16384;
        x_scale       = 24'd65536;
        y_scale       = 24'd65536;
        col_idx       = 0;
        cx            = 0;
        cy            = 0;
        bw            = 0;
        bh            = 0;
        obj           = 0;
        row_ok        = 1'b0;
        errors        = 0;
        values_seen   = 0;
        boxes_checked = 0;
        reg_writes    = 0;
    endfunction

    function void flag(string msg);
        errors++;
        if (errors <= 10) $display("ERROR: %s", msg);
    endfunction

    function void apply_reg(logic [dbd_pkg::ADDR_W-1:0] idx, logic [31:0] data);
        reg_writes++;
        case (idx)
            dbd_pkg::REG_NUM_COLUMNS:     cols = data[9:0];
            dbd_pkg::REG_SCORE_THRESHOLD: thr = data[16:0];
            dbd_pkg::REG_X_SCALE:         x_scale = data[23:0];
            dbd_pkg::REG_Y_SCALE:         y_scale = data[23:0];
            default: ;
        endcase
    endfunction

    // (2*centre -/+ size) * scale, floor shift by 17, clamp to 32 bits
    function logic signed [31:0] corner_px(logic signed [31:0] centre,
                                           logic signed [31:0] size,
                                           bit plus, logic [23:0] scale);
        longint edge_sum;
        longint sc;
        longint r;
        sc = {40'd0, scale};
        edge_sum = 2 * longint'(centre);
        if (plus) edge_sum = edge_sum + longint'(size);
        else edge_sum = edge_sum - longint'(size);
        r = (edge_sum * sc) >>> 17;
        if (r > 64'sd2147483647) r = 64'sd2147483647;
        if (r < -64'sd2147483648) r = -64'sd2147483648;
        return r[31:0];
    endfunction

    function void take_value(logic signed [31:0] v);
        int     eff_cols;
        longint thr_l;
        longint prod;
        longint s;
        box_t   b;
        eff_cols = cols;
        if (eff_cols < dbd_pkg::MIN_COLUMNS) eff_cols = dbd_pkg::MIN_COLUMNS;
        if (eff_cols > dbd_pkg::MAX_COLUMNS) eff_cols = dbd_pkg::MAX_COLUMNS;
        thr_l = {47'd0, thr};
        values_seen++;
        case (col_idx)
            COL_CENTRE_X: cx = v;
            COL_CENTRE_Y: cy = v;
            COL_WIDTH:    bw = v;
            COL_HEIGHT:   bh = v;
            COL_OBJECTNESS: begin
                obj = v;
                row_ok = (longint'(v) > thr_l) && (v <= dbd_pkg::ONE_Q16);
            end
            default: begin
                prod = longint'(v) * longint'(obj);
                if (row_ok && prod > (thr_l <<< 16)) begin
                    s = prod >>> 16;
                    if (s > 65536) s = 65536;
                    b.left     = corner_px(cx, bw, 1'b0, x_scale);
                    b.top      = corner_px(cy, bh, 1'b0, y_scale);
                    b.right    = corner_px(cx, bw, 1'b1, x_scale);
                    b.bottom   = corner_px(cy, bh, 1'b1, y_scale);
                    b.class_id = 9'(col_idx - dbd_pkg::FIRST_CLASS);
                    b.score    = s[16:0];
                    pending_boxes = {pending_boxes, b};
                end
            end
        endcase
        if (col_idx + 1 >= eff_cols) col_idx = 0;
        else col_idx = col_idx + 1;
    endfunction

    function void match_box(box_t got);
        box_t want;
        if (pending_boxes.size() == 0) begin
            flag($sformatf("box with none pending: class %0d score %0d",
                           got.class_id, got.score));
            return;
        end
        want = pending_boxes.pop_front();
        boxes_checked++;
        if (got.left !== want.left || got.top !== want.top || got.right !== want.right ||
            got.bottom !== want.bottom || got.class_id !== want.class_id ||
            got.score !== want.score) begin
            flag($sformatf("box %0d: want %0d %0d %0d %0d cls %0d score %0d",
                           boxes_checked, want.left, want.top, want.right, want.bottom,
                           want.class_id, want.score));
            if (errors <= 10)
                $display("       got  %0d %0d %0d %0d cls %0d score %0d",
                         got.left, got.top, got.right, got.bottom, got.class_id, got.score);
        end
    endfunction
endclass

module tb_detection_box_decoder_core;
    import dbd_pkg::*;

    localparam int RANDOM_ITEMS   = 550;
    localparam int DIRECTED_ITEMS = 21;
    localparam int DRAIN_CYCLES   = 10;
    localparam int HOLD_CYCLES    = 400;
    localparam int CYCLE_LIMIT    = 400000;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [ADDR_W-1:0]   cfg_addr;
    logic [DATA_W-1:0]   cfg_data;
    logic                s_valid;
    logic                s_ready;
    logic signed [31:0]  s_value;
    logic                m_valid;
    logic                m_ready;
    logic signed [31:0]  m_box_left;
    logic signed [31:0]  m_box_top;
    logic signed [31:0]  m_box_right;
    logic signed [31:0]  m_box_bottom;
    logic [CLASS_W-1:0]  m_class_id;
    logic [16:0]         m_score;

    bit                  hold_req = 1'b0;
    box_tracker_t        tracker = new();

    // rows of seven: saturating extremes, product just above and at threshold,
    // objectness equal to threshold
    logic signed [31:0] directed_vals [DIRECTED_ITEMS] = '{
        32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF,
        32'sd65536, 32'sh7FFFFFFF, 32'sh80000000,
        32'sd6553600, 32'sd3276800, 32'sd1310720, 32'sd655360,
        32'sd65536, 32'sd16385, 32'sd16384,
        32'sd6553600, 32'sd3276800, 32'sd1310720, 32'sd655360,
        32'sd16384, 32'sd65536, 32'sd65536
    };

    detection_box_decoder_core dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_addr     (cfg_addr),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_value      (s_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_box_left   (m_box_left),
        .m_box_top    (m_box_top),
        .m_box_right  (m_box_right),
        .m_box_bottom (m_box_bottom),
        .m_class_id   (m_class_id),
        .m_score      (m_score)
    );

    always #5 aclk = ~aclk;

    function automatic logic [31:0] with_junk(logic [31:0] val, int w);
        logic [31:0] keep;
        keep = (32'd1 << w) - 32'd1;
        return (val & keep) | ($urandom & ~keep);
    endfunction

    function automatic int pick_scale();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7) return $urandom_range(32768, 262144);
        if (r == 7) return 0;
        if (r == 8) return 24'hFFFFFF;
        return $urandom_range(0, 24'hFFFFFF);
    endfunction

    function automatic logic signed [31:0] pick_value(int col, logic [16:0] thr,
                                                      int noise_pct);
        int r;
        if ($urandom_range(0, 99) < noise_pct) return $urandom;
        r = $urandom_range(0, 99);
        case (col)
            COL_CENTRE_X, COL_CENTRE_Y, COL_WIDTH, COL_HEIGHT: begin
                if (r < 85) return $signed($urandom_range(0, 32'h0400_0000)) - 32'sh0100_0000;
                return $urandom;
            end
            COL_OBJECTNESS: begin
                if (r < 75 && thr < 17'd65536) return $urandom_range(thr + 1, 65536);
                if (r < 82) return 32'(thr);
                if (r < 89) return ONE_Q16;
                if (r < 94) return ONE_Q16 + 32'sd1;
                return $urandom;
            end
            default: begin
                if (r < 70) return $urandom_range(0, 65536);
                if (r < 80) return -$signed($urandom_range(0, 65536));
                if (r < 90) return ONE_Q16;
                return $urandom;
            end
        endcase
    endfunction

    task automatic put_reg(logic [ADDR_W-1:0] idx, logic [DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_addr  <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        tracker.apply_reg(idx, data);
    endtask

    task automatic load_config(int cols, int thr, int xs, int ys);
        put_reg(REG_NUM_COLUMNS, with_junk(cols, 10));
        put_reg(REG_SCORE_THRESHOLD, with_junk(thr, 17));
        put_reg(REG_X_SCALE, with_junk(xs, 24));
        put_reg(REG_Y_SCALE, with_junk(ys, 24));
        if ($urandom_range(0, 3) == 0)
            put_reg(ADDR_W'($urandom_range(REG_Y_SCALE + 1, 255)), $urandom);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_value(logic signed [31:0] v);
        s_valid <= 1'b1;
        s_value <= v;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        tracker.take_value(v);
    endtask

    task automatic run_phase(int count, int noise_pct, bit gapless);
        int burst_left;
        int gap;
        burst_left = $urandom_range(1, 24);
        for (int i = 0; i < count; i++) begin
            send_value(pick_value(tracker.col_idx, tracker.thr, noise_pct));
            burst_left = burst_left - 1;
            if (!gapless && burst_left == 0) begin
                gap = ($urandom_range(0, 5) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 3);
                if (gap > 0) begin
                    s_valid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
                burst_left = $urandom_range(1, 24);
            end
        end
        s_valid <= 1'b0;
    endtask

    // results can lag the last beat, so wait until no box is pending, then settle past the final box
    task automatic wait_drained();
        while (tracker.pending_boxes.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    initial begin : stimulus
        int phase;
        int r;
        int cols_v;
        int thr_v;
        int xs_v;
        int ys_v;
        aresetn   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_addr  <= '0;
        cfg_data  <= '0;
        s_valid   <= 1'b0;
        s_value   <= '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        load_config(7, 16384, 131072, 98304);
        for (int i = 0; i < DIRECTED_ITEMS; i++) send_value(directed_vals[i]);
        s_valid <= 1'b0;
        wait_drained();

        phase = 0;
        while (tracker.values_seen < DIRECTED_ITEMS + RANDOM_ITEMS) begin
            case (phase)
                0: begin
                    cols_v = 0; thr_v = 0; xs_v = 24'hFFFFFF; ys_v = 0;
                end
                1: begin
                    cols_v = 1023; thr_v = 65536; xs_v = 0; ys_v = 24'hFFFFFF;
                end
                2: begin
                    cols_v = 5; thr_v = 131071; xs_v = pick_scale(); ys_v = pick_scale();
                end
                3: begin
                    cols_v = 12; thr_v = 0; xs_v = 65536; ys_v = 65536;
                end
                default: begin
                    r = $urandom_range(0, 9);
                    cols_v = (r < 6) ? $urandom_range(6, 16) :
                             (r == 6) ? $urandom_range(0, 5) :
                             (r == 7) ? 85 :
                             (r == 8) ? $urandom_range(17, 200) : $urandom_range(513, 1023);
                    r = $urandom_range(0, 9);
                    thr_v = (r < 6) ? $urandom_range(0, 40000) :
                            (r == 6) ? 0 :
                            (r == 7) ? 65536 :
                            (r == 8) ? $urandom_range(65537, 131071) : 16384;
                    xs_v = pick_scale();
                    ys_v = pick_scale();
                end
            endcase
            load_config(cols_v, thr_v, xs_v, ys_v);
            if (phase == 3) begin
                hold_req = 1'b1;
                run_phase(90, 0, 1'b1);
            end else begin
                run_phase($urandom_range(30, 90), $urandom_range(0, 15),
                          $urandom_range(0, 4) == 0);
            end
            wait_drained();
            phase++;
        end

        if (tracker.pending_boxes.size() != 0)
            tracker.flag($sformatf("%0d boxes never arrived", tracker.pending_boxes.size()));
        $display("covered %0d values under %0d register settings, %0d boxes checked",
                 tracker.values_seen, phase + 1, tracker.boxes_checked);
        $display("%0d register writes, %0d failures", tracker.reg_writes, tracker.errors);
        if (tracker.errors == 0) begin
            $display("detection_box_decoder_core test passed");
        end else begin
            $display("detection_box_decoder_core test failed");
        end
        $finish;
    end

    initial begin : result_sink
        int         hold_left;
        int         mode_left;
        int         tick;
        sink_mode_t mode;
        box_t       got;
        hold_left = 0;
        mode_left = 0;
        tick      = 0;
        mode      = SINK_OPEN;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            tick++;
            if (m_valid && m_ready) begin
                got.left     = m_box_left;
                got.top      = m_box_top;
                got.right    = m_box_right;
                got.bottom   = m_box_bottom;
                got.class_id = m_class_id;
                got.score    = m_score;
                tracker.match_box(got);
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
                m_ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode = sink_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(20, 120);
                end
                mode_left--;
                case (mode)
                    SINK_OPEN:   m_ready <= 1'b1;
                    SINK_BUSY:   m_ready <= ($urandom_range(0, 9) < 7);
                    SINK_SPARSE: m_ready <= ($urandom_range(0, 9) < 3);
                    default:     m_ready <= (tick % 4 == 0);
                endcase
            end
        end
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("detection_box_decoder_core test failed");
        $finish;
    end

endmodule
